>>> sv/zmtp_pkg.sv
// ----------------------------------------------------------------------------
// ZMTP deframer package
// Types, codes and constants shared by the frame deframer and its flags decoder.
// ----------------------------------------------------------------------------
package zmtp_pkg;

    // Width of the capacity register and of the body byte counter.
    localparam int CAP_W = 17;
    // Largest receive buffer that the block honours.
    localparam logic [CAP_W-1:0] MAX_CAPACITY = 17'd65536;
    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;

    // Number of length bytes in a short and a long frame header.
    localparam logic [3:0] LEN_BYTES_SHORT = 4'd1;
    localparam logic [3:0] LEN_BYTES_LONG  = 4'd8;

    // Flags byte codes.
    localparam logic [7:0] FLG_SHORT_LAST = 8'h00;
    localparam logic [7:0] FLG_SHORT_MORE = 8'h01;
    localparam logic [7:0] FLG_LONG_LAST  = 8'h02;
    localparam logic [7:0] FLG_LONG_MORE  = 8'h03;
    localparam logic [7:0] FLG_SHORT_CMD  = 8'h04;
    localparam logic [7:0] FLG_LONG_CMD   = 8'h06;

    typedef enum logic [1:0] {
        PH_FLAGS  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PART_FLAGS  = 2'd0,
        PART_LENGTH = 2'd1,
        PART_BODY   = 2'd2
    } part_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FLAGS = 2'd1,
        ERR_SIZE  = 2'd2
    } err_t;

    // Decoded flags byte.
    typedef struct packed {
        logic known;
        logic long_len;
        logic message;
        logic last;
    } flags_t;

endpackage

>>> sv/zmtp_byte_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one byte of the incoming stream.
// ----------------------------------------------------------------------------
interface zmtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/zmtp_tag_if.sv
// ----------------------------------------------------------------------------
// Tagged byte channel
// Valid/ready channel that carries one byte with its frame tags.
// ----------------------------------------------------------------------------
interface zmtp_tag_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] frame_part;
    logic       msg_frame;
    logic       is_last_part;
    logic       frame_end;
    logic [1:0] error_code;

    modport source (output valid, output data_byte, output frame_part, output msg_frame,
                    output is_last_part, output frame_end, output error_code, input ready);
    modport sink   (input valid, input data_byte, input frame_part, input msg_frame,
                    input is_last_part, input frame_end, input error_code, output ready);
endinterface

>>> sv/zmtp_flags_decoder.sv
// ----------------------------------------------------------------------------
// ZMTP flags decoder
// Maps a flags byte onto length size, frame kind and last-part mark.
// ----------------------------------------------------------------------------
module zmtp_flags_decoder
    import zmtp_pkg::*;
(
    input  logic [7:0] flags_byte,
    output flags_t     flags
);

    always_comb
    begin
        unique case (flags_byte)
            FLG_SHORT_LAST: flags = '{known: 1'b1, long_len: 1'b0, message: 1'b1, last: 1'b1};
            FLG_SHORT_MORE: flags = '{known: 1'b1, long_len: 1'b0, message: 1'b1, last: 1'b0};
            FLG_LONG_LAST:  flags = '{known: 1'b1, long_len: 1'b1, message: 1'b1, last: 1'b1};
            FLG_LONG_MORE:  flags = '{known: 1'b1, long_len: 1'b1, message: 1'b1, last: 1'b0};
            FLG_SHORT_CMD:  flags = '{known: 1'b1, long_len: 1'b0, message: 1'b0, last: 1'b0};
            FLG_LONG_CMD:   flags = '{known: 1'b1, long_len: 1'b1, message: 1'b0, last: 1'b0};
            // A command never carries the last mark; anything else is unknown.
            default:        flags = '{known: 1'b0, long_len: 1'b0, message: 1'b0, last: 1'b0};
        endcase
    end

endmodule

>>> sv/zmtp_frame_deframer.sv
// ----------------------------------------------------------------------------
// ZMTP frame deframer
// Splits a received byte stream into ZMTP 3 frames and tags every byte.
// ----------------------------------------------------------------------------
// The deframer takes one byte per clock cycle while its output register is
// empty or being drained, and returns one tagged byte per byte taken, in
// order, through that register, in the cycle after the byte is taken; with a
// ready sink the throughput is one byte per cycle. Each frame is a flags
// byte, a one-byte or eight-byte big-endian length and then the body.
// Every byte is tagged with its part of the frame, whether the frame is a
// message or a command, whether it is the last message part, and a frame-end
// mark on the final byte (the last length byte when the body is empty). An
// unknown flags byte or a body length not strictly below the buffer capacity
// raises an error that sticks until reset; from then on bytes are passed
// through with neutral tags and the error code. The capacity register may be
// written only while the block is idle; values above 65536 act as 65536.
// ----------------------------------------------------------------------------
module zmtp_frame_deframer
    import zmtp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    zmtp_byte_if.sink        rx,
    zmtp_tag_if.source       tx
);

    // Configuration, stored already clamped to the largest capacity.
    logic [CAP_W-1:0] cap_reg;

    // Parser state.
    phase_t           phase_reg, phase_next;
    logic [3:0]       len_left_reg, len_left_next;
    // Only the low 17 bits of the length are kept; the big flag records that
    // some higher bit has been set, which makes the length too large anyway.
    logic [CAP_W-1:0] acc_reg, acc_next;
    logic             big_reg, big_next;
    logic [CAP_W-1:0] body_left_reg, body_left_next;
    logic             msg_reg, msg_next;
    logic             last_reg, last_next;
    err_t             err_reg, err_next;

    // Output register.
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    part_t            out_part_reg, out_part_next;
    logic             out_msg_reg, out_msg_next;
    logic             out_last_reg, out_last_next;
    logic             out_end_reg, out_end_next;

    logic             accept;
    flags_t           flags;

    // Events that the phase logic acts on.
    logic             len_done;
    logic             len_too_big;
    logic             len_zero;
    logic             body_done;
    logic [3:0]       len_left_dec;
    logic [CAP_W-1:0] body_left_dec;

    // A new byte is taken whenever the output register is empty or is being
    // emptied in this same cycle.
    assign rx.ready = !out_valid_reg || tx.ready;
    assign accept   = rx.valid && rx.ready;

    zmtp_flags_decoder u_flags_decoder (
        .flags_byte (rx.rx_byte),
        .flags      (flags)
    );

    // Counter and length evaluation for the byte on the input.
    always_comb
    begin
        len_left_dec  = (len_left_reg != 4'd0) ? (len_left_reg - 4'd1) : 4'd0;
        body_left_dec = (body_left_reg != '0) ? (body_left_reg - CAP_W'(1)) : '0;
        acc_next      = {acc_reg[CAP_W-9:0], rx.rx_byte};
        big_next      = big_reg || (acc_reg[CAP_W-1:CAP_W-8] != 8'd0);
        len_done      = (len_left_dec == 4'd0);
        len_too_big   = big_next || (acc_next >= cap_reg);
        len_zero      = (acc_next == '0);
        body_done     = (body_left_dec == '0);
    end

    // Next phase and sticky error.
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        if (err_reg == ERR_NONE)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    if (len_done)
                    begin
                        if (len_too_big)
                            err_next = ERR_SIZE;
                        else if (len_zero)
                            phase_next = PH_FLAGS;
                        else
                            phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (body_done)
                        phase_next = PH_FLAGS;
                end
                default:
                begin
                    // The unused phase code behaves as the flags phase.
                    if (flags.known)
                        phase_next = PH_LENGTH;
                    else
                        err_next = ERR_FLAGS;
                end
            endcase
        end
    end

    // Datapath updates and the tags for the byte on the input.
    always_comb
    begin
        len_left_next  = len_left_reg;
        body_left_next = body_left_reg;
        msg_next       = msg_reg;
        last_next      = last_reg;
        out_part_next  = PART_FLAGS;
        out_msg_next   = 1'b0;
        out_last_next  = 1'b0;
        out_end_next   = 1'b0;
        if (err_reg == ERR_NONE)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    out_part_next = PART_LENGTH;
                    out_msg_next  = msg_reg;
                    out_last_next = last_reg;
                    len_left_next = len_left_dec;
                    if (len_done && !len_too_big)
                    begin
                        out_end_next   = len_zero;
                        body_left_next = acc_next;
                    end
                end
                PH_BODY:
                begin
                    out_part_next  = PART_BODY;
                    out_msg_next   = msg_reg;
                    out_last_next  = last_reg;
                    body_left_next = body_left_dec;
                    out_end_next   = body_done;
                end
                default:
                begin
                    if (flags.known)
                    begin
                        msg_next      = flags.message;
                        last_next     = flags.last;
                        len_left_next = flags.long_len ? LEN_BYTES_LONG : LEN_BYTES_SHORT;
                        out_msg_next  = flags.message;
                        out_last_next = flags.last;
                    end
                end
            endcase
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            phase_reg     <= PH_FLAGS;
            len_left_reg  <= 4'd0;
            acc_reg       <= '0;
            big_reg       <= 1'b0;
            body_left_reg <= '0;
            msg_reg       <= 1'b0;
            last_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= (cfg_wr_data > MAX_CAPACITY) ? MAX_CAPACITY : cfg_wr_data;
            if (accept)
            begin
                phase_reg     <= phase_next;
                len_left_reg  <= len_left_next;
                body_left_reg <= body_left_next;
                msg_reg       <= msg_next;
                last_reg      <= last_next;
                err_reg       <= err_next;
                // A fresh flags byte starts a new length accumulation.
                if (err_reg == ERR_NONE && phase_reg == PH_LENGTH)
                begin
                    acc_reg <= acc_next;
                    big_reg <= big_next;
                end
                else if (err_reg == ERR_NONE && phase_reg != PH_BODY)
                begin
                    acc_reg <= '0;
                    big_reg <= 1'b0;
                end
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (tx.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload; it only changes when a transaction is taken in.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg <= rx.rx_byte;
            out_part_reg <= out_part_next;
            out_msg_reg  <= out_msg_next;
            out_last_reg <= out_last_next;
            out_end_reg  <= out_end_next;
        end
    end

    assign tx.valid        = out_valid_reg;
    assign tx.data_byte    = out_byte_reg;
    assign tx.frame_part   = out_part_reg;
    assign tx.msg_frame    = out_msg_reg;
    assign tx.is_last_part = out_last_reg;
    assign tx.frame_end    = out_end_reg;
    // The error register moves with the transaction that raised it, so the
    // stored code is the one belonging to the byte in the output register.
    assign tx.error_code   = err_reg;

endmodule
